>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PHFP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phfp same-cycle check failed");

`define PHFP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phfp next-cycle check failed");

`endif

>>> rtl/phfp_pkg.sv
package phfp_pkg;

    localparam int SNAP_LENGTH = 16384;
    localparam int POS_W       = $clog2(SNAP_LENGTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_IS_ETH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUESS_EN    = 1'd1;

    localparam int ETH_HDR_LEN = 14;
    localparam int V4_MIN_LEN  = 20;
    localparam int V6_HDR_LEN  = 40;
    localparam int TCP_MIN_LEN = 20;
    localparam int UDP_HDR_LEN = 8;

    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
    localparam logic [7:0]  IPV4_SNIFF  = 8'h45;
    localparam logic [3:0]  IPV6_NIBBLE = 4'h6;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [7:0] OPT_NOP     = 8'd1;
    localparam logic [7:0] OPT_MSS     = 8'd2;
    localparam logic [7:0] OPT_MSS_LEN = 8'd4;

    localparam logic [1:0] L3_NONE = 2'd0;
    localparam logic [1:0] L3_IPV4 = 2'd1;
    localparam logic [1:0] L3_IPV6 = 2'd2;
    localparam logic [1:0] L4_NONE = 2'd0;
    localparam logic [1:0] L4_TCP  = 2'd1;
    localparam logic [1:0] L4_UDP  = 2'd2;

    localparam int ST_TRUNC    = 0;
    localparam int ST_EMPTY    = 1;
    localparam int ST_MSS_SEEN = 2;
    localparam int ST_SERVER   = 3;

    // Header fields gathered while a packet streams in
    typedef struct packed {
        logic [POS_W-1:0] cap;
        logic [15:0]      et_raw;
        logic [7:0]       ipb0;
        logic [15:0]      v4_len;
        logic [15:0]      v6_plen;
        logic [7:0]       v6_nh;
        logic [7:0]       v6_hop;
        logic [7:0]       v4_ttl;
        logic [7:0]       v4_proto;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [15:0]      ulen;
        logic [7:0]       tcp_off;
        logic [7:0]       flags;
        logic [15:0]      mss;
        logic             mss_seen;
    } hdr_snap_t;

    typedef struct packed {
        logic [15:0] ethertype;
        logic [1:0]  l3_kind;
        logic [15:0] ip_length;
        logic [7:0]  ip_proto;
        logic [7:0]  hop_limit;
        logic [1:0]  l4_kind;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
        logic [15:0] tcp_mss;
        logic [15:0] content_length;
        logic [3:0]  status_bits;
    } result_t;

endpackage

>>> rtl/phfp_capture.sv
module phfp_capture (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic                 link_eth,
    output phfp_pkg::hdr_snap_t  snap,
    output logic                 snap_valid,
    input  logic                 snap_ready
);

    localparam int PW = phfp_pkg::POS_W;

    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_KIND = 3'd1;
    localparam logic [2:0] W_LEN  = 3'd2;
    localparam logic [2:0] W_MSS1 = 3'd3;
    localparam logic [2:0] W_MSS2 = 3'd4;

    phfp_pkg::hdr_snap_t work_reg, work_next, upd;
    phfp_pkg::hdr_snap_t snap_reg;
    logic                snap_valid_reg, snap_valid_next;
    logic [6:0]          base_reg, base_next;
    logic [2:0]          w_phase_reg, w_phase_next, w_phase_upd;
    logic [7:0]          w_pos_reg, w_pos_next;
    logic [5:0]          w_left_reg, w_left_next;
    logic                w_kind2_reg, w_kind2_next;
    logic [7:0]          mss_hi_reg, mss_hi_next;

    logic          acc, take, at_link, base_ok, in_tcp, start, kind_ev;
    logic [PW-1:0] link_pos, ipoff, toff;
    logic [6:0]    base_now;
    logic [5:0]    tb, thl, lcur, newl;
    logic [7:0]    pos8;

    assign in_ready   = !snap_valid_reg || snap_ready;
    assign acc        = in_valid && in_ready;
    assign take       = acc && (work_reg.cap < PW'(phfp_pkg::SNAP_LENGTH));
    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;

    always_comb
    begin
        link_pos = link_eth ? PW'(phfp_pkg::ETH_HDR_LEN) : '0;
        at_link  = work_reg.cap == link_pos;
        base_ok  = work_reg.cap >= link_pos;
        ipoff    = work_reg.cap - link_pos;
        if ((data_byte[7:4] == phfp_pkg::IPV6_NIBBLE) ||
            (link_eth && (work_reg.et_raw == phfp_pkg::ETYPE_IPV6)))
        begin
            tb = 6'(phfp_pkg::V6_HDR_LEN);
        end
        else
        begin
            tb = {data_byte[3:0], 2'b00};
        end
        base_now = at_link ? (7'(link_pos) + {1'b0, tb}) : base_reg;
        in_tcp   = base_ok && (work_reg.cap >= PW'(base_now));
        toff     = work_reg.cap - PW'(base_now);
        thl      = {work_reg.tcp_off[7:4], 2'b00};
        pos8     = work_reg.cap[7:0];
        start    = in_tcp && (toff == PW'(phfp_pkg::TCP_MIN_LEN))
                   && (thl > 6'(phfp_pkg::TCP_MIN_LEN));
        kind_ev  = start || ((w_phase_reg == W_KIND) && (work_reg.cap == PW'(w_pos_reg)));
        lcur     = start ? (thl - 6'(phfp_pkg::TCP_MIN_LEN)) : w_left_reg;
        newl     = w_left_reg - data_byte[5:0];

        upd          = work_reg;
        base_next    = base_reg;
        w_phase_upd  = w_phase_reg;
        w_pos_next   = w_pos_reg;
        w_left_next  = w_left_reg;
        w_kind2_next = w_kind2_reg;
        mss_hi_next  = mss_hi_reg;

        if (take)
        begin
            upd.cap = work_reg.cap + PW'(1);
            if (work_reg.cap == PW'(12))
            begin
                upd.et_raw[15:8] = data_byte;
            end
            if (work_reg.cap == PW'(13))
            begin
                upd.et_raw[7:0] = data_byte;
            end
            if (at_link)
            begin
                base_next = base_now;
            end
            if (base_ok)
            begin
                case (ipoff)
                    PW'(0): upd.ipb0          = data_byte;
                    PW'(2): upd.v4_len[15:8]  = data_byte;
                    PW'(3): upd.v4_len[7:0]   = data_byte;
                    PW'(4): upd.v6_plen[15:8] = data_byte;
                    PW'(5): upd.v6_plen[7:0]  = data_byte;
                    PW'(6): upd.v6_nh         = data_byte;
                    PW'(7): upd.v6_hop        = data_byte;
                    PW'(8): upd.v4_ttl        = data_byte;
                    PW'(9): upd.v4_proto      = data_byte;
                    default: ;
                endcase
            end
            if (in_tcp)
            begin
                case (toff)
                    PW'(0):  upd.sport[15:8] = data_byte;
                    PW'(1):  upd.sport[7:0]  = data_byte;
                    PW'(2):  upd.dport[15:8] = data_byte;
                    PW'(3):  upd.dport[7:0]  = data_byte;
                    PW'(4):  upd.ulen[15:8]  = data_byte;
                    PW'(5):  upd.ulen[7:0]   = data_byte;
                    PW'(12): upd.tcp_off     = data_byte;
                    PW'(13): upd.flags       = data_byte;
                    default: ;
                endcase
            end

            // Option walk: follow option starts as their bytes go by
            if (kind_ev)
            begin
                case (data_byte)
                    phfp_pkg::OPT_NOP:
                    begin
                        if (lcur == 6'd1)
                        begin
                            w_phase_upd = W_IDLE;
                        end
                        else
                        begin
                            w_phase_upd = W_KIND;
                            w_left_next = lcur - 6'd1;
                            w_pos_next  = pos8 + 8'd1;
                        end
                    end
                    phfp_pkg::OPT_MSS:
                    begin
                        w_kind2_next = 1'b1;
                        w_left_next  = lcur;
                        w_phase_upd  = ({2'b00, lcur} >= phfp_pkg::OPT_MSS_LEN) ? W_LEN : W_IDLE;
                    end
                    default:
                    begin
                        w_kind2_next = 1'b0;
                        w_left_next  = lcur;
                        w_phase_upd  = (lcur >= 6'd2) ? W_LEN : W_IDLE;
                    end
                endcase
            end
            else if (w_phase_reg == W_LEN)
            begin
                if ((data_byte == 8'd0) || (data_byte > {2'b00, w_left_reg}))
                begin
                    w_phase_upd = W_IDLE;
                end
                else if (w_kind2_reg && (data_byte == phfp_pkg::OPT_MSS_LEN))
                begin
                    w_phase_upd = W_MSS1;
                    w_left_next = w_left_reg - 6'(phfp_pkg::OPT_MSS_LEN);
                end
                else if (newl == 6'd0)
                begin
                    w_phase_upd = W_IDLE;
                end
                else if (data_byte == 8'd1)
                begin
                    // length of one: this byte is also the next option, a no-op
                    if (newl == 6'd1)
                    begin
                        w_phase_upd = W_IDLE;
                    end
                    else
                    begin
                        w_phase_upd = W_KIND;
                        w_left_next = newl - 6'd1;
                        w_pos_next  = pos8 + 8'd1;
                    end
                end
                else
                begin
                    w_phase_upd = W_KIND;
                    w_left_next = newl;
                    w_pos_next  = pos8 + data_byte - 8'd1;
                end
            end
            else if (w_phase_reg == W_MSS1)
            begin
                mss_hi_next = data_byte;
                w_phase_upd = W_MSS2;
            end
            else if (w_phase_reg == W_MSS2)
            begin
                upd.mss      = {mss_hi_reg, data_byte};
                upd.mss_seen = 1'b1;
                if (w_left_reg == 6'd0)
                begin
                    w_phase_upd = W_IDLE;
                end
                else
                begin
                    w_phase_upd = W_KIND;
                    w_pos_next  = pos8 + 8'd1;
                end
            end
        end

        // Start the next packet fresh after the marked byte
        work_next    = upd;
        w_phase_next = w_phase_upd;
        if (acc && last_byte)
        begin
            work_next.cap      = '0;
            work_next.mss_seen = 1'b0;
            w_phase_next       = W_IDLE;
        end

        snap_valid_next = snap_valid_reg;
        if (snap_ready)
        begin
            snap_valid_next = 1'b0;
        end
        if (acc && last_byte)
        begin
            snap_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg       <= '0;
            snap_valid_reg <= 1'b0;
            w_phase_reg    <= W_IDLE;
        end
        else
        begin
            work_reg       <= work_next;
            snap_valid_reg <= snap_valid_next;
            w_phase_reg    <= w_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        w_pos_reg   <= w_pos_next;
        w_left_reg  <= w_left_next;
        w_kind2_reg <= w_kind2_next;
        mss_hi_reg  <= mss_hi_next;
        if (acc && last_byte)
        begin
            snap_reg <= upd;
        end
    end

endmodule

>>> rtl/phfp_summary.sv
module phfp_summary (
    input  logic                clk,
    input  logic                rst_n,
    input  phfp_pkg::hdr_snap_t snap,
    input  logic                snap_valid,
    output logic                snap_ready,
    input  logic                link_eth,
    input  logic                guess_en,
    output phfp_pkg::result_t   res,
    output logic                res_valid,
    input  logic                res_ready
);

    localparam int PW = phfp_pkg::POS_W;

    phfp_pkg::result_t res_reg, r;
    logic              res_valid_reg;

    logic [PW-1:0] link_len, llen;
    logic [15:0]   et, l16, avail6, ihl16, rem, true_len, thl16;
    logic          reach, v4path, is_v6, v6ok, v4ok, stop4, trunc4, trunc6, go;
    logic          tcp_ok, udp_ok, opt_ok;
    logic [7:0]    proto;

    assign snap_ready = !res_valid_reg || res_ready;
    assign res        = res_reg;
    assign res_valid  = res_valid_reg;

    always_comb
    begin
        r        = '0;
        link_len = link_eth ? PW'(phfp_pkg::ETH_HDR_LEN) : '0;
        llen     = snap.cap - link_len;
        l16      = 16'(llen);
        et       = 16'd0;
        if (link_eth)
        begin
            if (snap.cap > PW'(phfp_pkg::ETH_HDR_LEN))
            begin
                et = snap.et_raw;
            end
        end
        else if (snap.cap >= PW'(phfp_pkg::V4_MIN_LEN))
        begin
            if (snap.ipb0 == phfp_pkg::IPV4_SNIFF)
            begin
                et = phfp_pkg::ETYPE_IPV4;
            end
            else if (snap.ipb0[7:4] == phfp_pkg::IPV6_NIBBLE)
            begin
                et = phfp_pkg::ETYPE_IPV6;
            end
        end
        r.ethertype = et;

        reach  = snap.cap > link_len;
        v4path = et == phfp_pkg::ETYPE_IPV4;
        is_v6  = (et == phfp_pkg::ETYPE_IPV6)
                 || (v4path && (snap.ipb0[7:4] == phfp_pkg::IPV6_NIBBLE));
        v6ok   = reach && is_v6 && (l16 >= 16'(phfp_pkg::V6_HDR_LEN));
        v4ok   = reach && v4path && !is_v6 && (l16 >= 16'(phfp_pkg::V4_MIN_LEN));

        avail6 = l16 - 16'(phfp_pkg::V6_HDR_LEN);
        trunc6 = avail6 < snap.v6_plen;
        ihl16  = {10'd0, snap.ipb0[3:0], 2'b00};
        stop4  = (ihl16 > snap.v4_len) || (l16 < ihl16);
        trunc4 = l16 < snap.v4_len;

        if (v6ok)
        begin
            r.l3_kind   = phfp_pkg::L3_IPV6;
            r.ip_length = snap.v6_plen + 16'(phfp_pkg::V6_HDR_LEN);
            proto       = snap.v6_nh;
            r.hop_limit = snap.v6_hop;
            r.status_bits[phfp_pkg::ST_TRUNC] = trunc6;
            rem         = trunc6 ? avail6 : snap.v6_plen;
            true_len    = snap.v6_plen;
            go          = rem != 16'd0;
        end
        else
        begin
            r.l3_kind   = v4ok ? phfp_pkg::L3_IPV4 : phfp_pkg::L3_NONE;
            r.ip_length = v4ok ? snap.v4_len : 16'd0;
            proto       = v4ok ? snap.v4_proto : 8'd0;
            r.hop_limit = v4ok ? snap.v4_ttl : 8'd0;
            r.status_bits[phfp_pkg::ST_TRUNC] = v4ok && !stop4 && trunc4;
            true_len    = snap.v4_len - ihl16;
            rem         = trunc4 ? (l16 - ihl16) : true_len;
            go          = v4ok && !stop4 && (rem != 16'd0);
        end
        r.ip_proto = proto;

        tcp_ok = go && (proto == phfp_pkg::PROTO_TCP) && (rem >= 16'(phfp_pkg::TCP_MIN_LEN));
        udp_ok = go && (proto == phfp_pkg::PROTO_UDP) && (rem >= 16'(phfp_pkg::UDP_HDR_LEN));
        thl16  = {10'd0, snap.tcp_off[7:4], 2'b00};
        opt_ok = (thl16 >= 16'(phfp_pkg::TCP_MIN_LEN)) && (thl16 <= rem);

        if (tcp_ok || udp_ok)
        begin
            r.l4_kind  = tcp_ok ? phfp_pkg::L4_TCP : phfp_pkg::L4_UDP;
            r.src_port = snap.sport;
            r.dst_port = snap.dport;
            r.status_bits[phfp_pkg::ST_SERVER] = guess_en && (snap.sport <= snap.dport);
        end
        if (tcp_ok)
        begin
            r.tcp_flags = snap.flags;
            if (opt_ok)
            begin
                r.tcp_mss        = snap.mss_seen ? snap.mss : 16'd0;
                r.status_bits[phfp_pkg::ST_MSS_SEEN] = snap.mss_seen;
                r.content_length = (rem < true_len) ? (true_len - thl16) : (rem - thl16);
                r.status_bits[phfp_pkg::ST_EMPTY] = rem == thl16;
            end
        end
        if (udp_ok && (snap.ulen >= 16'(phfp_pkg::UDP_HDR_LEN)))
        begin
            r.content_length = snap.ulen - 16'(phfp_pkg::UDP_HDR_LEN);
            r.status_bits[phfp_pkg::ST_EMPTY] = snap.ulen == 16'(phfp_pkg::UDP_HDR_LEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            res_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid && snap_ready)
        begin
            res_reg <= r;
        end
    end

endmodule

>>> rtl/packet_header_field_parser.sv
// Channel   Handshake             Payload
// in        in_valid / in_ready   data_byte, last_byte
// out       out_valid / out_ready ethertype .. status_bits (one word per packet)
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is taken per cycle; header fields and the TCP option walk update as bytes pass.
// A packet summary is latched into the snapshot register with its marked byte, then passes
// through the summary logic into the output register.
// in_ready drops only while a finished packet waits behind a stalled output word.
// Reset: link_is_ethernet = 1, guess_server_enable = 0, byte count zero.
module packet_header_field_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [15:0]                     ethertype,
    output logic [1:0]                      l3_kind,
    output logic [15:0]                     ip_length,
    output logic [7:0]                      ip_proto,
    output logic [7:0]                      hop_limit,
    output logic [1:0]                      l4_kind,
    output logic [15:0]                     src_port,
    output logic [15:0]                     dst_port,
    output logic [7:0]                      tcp_flags,
    output logic [15:0]                     tcp_mss,
    output logic [15:0]                     content_length,
    output logic [3:0]                      status_bits,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [phfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data
);

    logic                link_eth_reg, guess_en_reg;
    phfp_pkg::hdr_snap_t snap;
    logic                snap_valid, snap_ready;
    phfp_pkg::result_t   res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_eth_reg <= 1'b1;
            guess_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                phfp_pkg::CFG_LINK_IS_ETH: link_eth_reg <= cfg_data;
                phfp_pkg::CFG_GUESS_EN:    guess_en_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    phfp_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .link_eth   (link_eth_reg),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready)
    );

    phfp_summary u_summary (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .link_eth   (link_eth_reg),
        .guess_en   (guess_en_reg),
        .res        (res),
        .res_valid  (out_valid),
        .res_ready  (out_ready)
    );

    assign ethertype      = res.ethertype;
    assign l3_kind        = res.l3_kind;
    assign ip_length      = res.ip_length;
    assign ip_proto       = res.ip_proto;
    assign hop_limit      = res.hop_limit;
    assign l4_kind        = res.l4_kind;
    assign src_port       = res.src_port;
    assign dst_port       = res.dst_port;
    assign tcp_flags      = res.tcp_flags;
    assign tcp_mss        = res.tcp_mss;
    assign content_length = res.content_length;
    assign status_bits    = res.status_bits;

endmodule

>>> rtl/phfp_checker.sv
`include "assert_macros.svh"

module phfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] ethertype,
    input logic [1:0]  l3_kind,
    input logic [15:0] ip_length,
    input logic [7:0]  ip_proto,
    input logic [1:0]  l4_kind,
    input logic [15:0] src_port,
    input logic [15:0] dst_port,
    input logic [3:0]  status_bits
);

    // hold a stalled word
    `PHFP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ethertype))
    `PHFP_ASSERT_IMP(a_l4_needs_l3, out_valid && (l4_kind != phfp_pkg::L4_NONE), l3_kind != phfp_pkg::L3_NONE)
    `PHFP_ASSERT_IMP(a_no_l3_zero, out_valid && (l3_kind == phfp_pkg::L3_NONE), (ip_length == 16'd0) && (ip_proto == 8'd0))
    `PHFP_ASSERT_IMP(a_mss_tcp, out_valid && status_bits[phfp_pkg::ST_MSS_SEEN], l4_kind == phfp_pkg::L4_TCP)
    `PHFP_ASSERT_IMP(a_no_l4_ports, out_valid && (l4_kind == phfp_pkg::L4_NONE), (src_port == 16'd0) && (dst_port == 16'd0))

endmodule

bind packet_header_field_parser phfp_checker u_phfp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ethertype   (ethertype),
    .l3_kind     (l3_kind),
    .ip_length   (ip_length),
    .ip_proto    (ip_proto),
    .l4_kind     (l4_kind),
    .src_port    (src_port),
    .dst_port    (dst_port),
    .status_bits (status_bits)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import phfp_pkg::*;

    localparam int HDR_KEEP   = 136;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic [7:0] d;
        logic       l;
    } byte_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] ethertype;
    logic [1:0]  l3_kind;
    logic [15:0] ip_length;
    logic [7:0]  ip_proto;
    logic [7:0]  hop_limit;
    logic [1:0]  l4_kind;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
    logic [15:0] tcp_mss;
    logic [15:0] content_length;
    logic [3:0]  status_bits;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic        cfg_data;

    packet_header_field_parser u_dut (.*);

    // stimulus and prediction state
    byte_word_t  byte_fifo[$];
    logic [7:0]  pkt[$];
    result_t     summary_q[$];
    result_t     sum_r;
    logic [7:0]  hdr_buf[HDR_KEEP];
    int unsigned cap_count;
    bit          model_eth;
    bit          model_guess;
    bit          quiet;
    int          errors;
    int          packets_done;
    int          bytes_done;
    int          in_gap;
    int          out_stall;
    int          idle_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- header summary predictor ----------------
    function automatic int unsigned hb(int unsigned i);
        return (i < HDR_KEEP) ? hdr_buf[i] : 0;
    endfunction

    function automatic int unsigned hw(int unsigned i);
        return (hb(i) << 8) | hb(i + 1);
    endfunction

    function automatic void mark_server();
        if (model_guess && sum_r.src_port <= sum_r.dst_port)
            sum_r.status_bits[ST_SERVER] = 1'b1;
    endfunction

    function automatic void sum_udp(int unsigned base, int unsigned len);
        int unsigned ulen;
        if (len < UDP_HDR_LEN)
            return;
        sum_r.l4_kind  = L4_UDP;
        sum_r.src_port = hw(base);
        sum_r.dst_port = hw(base + 2);
        ulen = hw(base + 4);
        mark_server();
        if (ulen < UDP_HDR_LEN)
            return;
        sum_r.content_length = ulen - UDP_HDR_LEN;
        if (ulen == UDP_HDR_LEN)
            sum_r.status_bits[ST_EMPTY] = 1'b1;
    endfunction

    function automatic void sum_tcp(int unsigned base, int unsigned len, int unsigned true_len);
        int unsigned thl;
        int unsigned pos;
        int unsigned kind;
        int unsigned olen;
        int          left;
        if (len < TCP_MIN_LEN)
            return;
        sum_r.l4_kind   = L4_TCP;
        sum_r.src_port  = hw(base);
        sum_r.dst_port  = hw(base + 2);
        sum_r.tcp_flags = hb(base + 13);
        mark_server();
        thl = (hb(base + 12) >> 4) * 4;
        if (thl < TCP_MIN_LEN || thl > len)
            return;
        pos  = base + 20;
        left = int'(thl) - 20;
        while (left > 0)
        begin
            kind = hb(pos);
            if (kind == OPT_NOP)
            begin
                pos++;
                left--;
            end
            else if (kind == OPT_MSS)
            begin
                if (left >= 4)
                begin
                    olen = hb(pos + 1);
                    if (olen == OPT_MSS_LEN)
                    begin
                        sum_r.tcp_mss = hw(pos + 2);
                        sum_r.status_bits[ST_MSS_SEEN] = 1'b1;
                    end
                    if (olen == 0)
                        left = 0;
                    else
                    begin
                        left -= int'(olen);
                        pos  += olen;
                    end
                end
                else
                    left = 0;
            end
            else
            begin
                olen = (left >= 2) ? hb(pos + 1) : 0;
                if (olen != 0 && int'(olen) <= left)
                begin
                    left -= int'(olen);
                    pos  += olen;
                end
                else
                    left = 0;
            end
        end
        if (len < true_len)
            sum_r.content_length = 16'(true_len - thl);
        else
            sum_r.content_length = 16'(len - thl);
        if (len == thl)
            sum_r.status_bits[ST_EMPTY] = 1'b1;
    endfunction

    function automatic void sum_l4(int unsigned base, int unsigned len, int unsigned tl);
        if (sum_r.ip_proto == PROTO_TCP)
            sum_tcp(base, len, tl);
        else if (sum_r.ip_proto == PROTO_UDP)
            sum_udp(base, len);
    endfunction

    function automatic void sum_v6(int unsigned base, int unsigned len);
        int unsigned plen;
        int unsigned rem;
        if (len < V6_HDR_LEN)
            return;
        sum_r.l3_kind   = L3_IPV6;
        plen            = hw(base + 4);
        sum_r.ip_length = 16'(plen + V6_HDR_LEN);
        sum_r.ip_proto  = hb(base + 6);
        sum_r.hop_limit = hb(base + 7);
        rem = plen;
        if (len - V6_HDR_LEN < plen)
        begin
            sum_r.status_bits[ST_TRUNC] = 1'b1;
            rem = len - V6_HDR_LEN;
        end
        if (rem != 0)
            sum_l4(base + V6_HDR_LEN, rem, plen);
    endfunction

    function automatic void sum_v4(int unsigned base, int unsigned len);
        int unsigned iplen;
        int unsigned ihl;
        int unsigned rem;
        int unsigned dremain;
        if (len < V4_MIN_LEN)
            return;
        if ((hb(base) >> 4) == IPV6_NIBBLE)
        begin
            sum_v6(base, len);
            return;
        end
        sum_r.l3_kind   = L3_IPV4;
        iplen           = hw(base + 2);
        ihl             = (hb(base) & 4'hF) * 4;
        sum_r.ip_length = iplen;
        sum_r.ip_proto  = hb(base + 9);
        sum_r.hop_limit = hb(base + 8);
        if (ihl > iplen || len < ihl)
            return;
        dremain = iplen - ihl;
        rem     = dremain;
        if (len < iplen)
        begin
            rem = len - ihl;
            sum_r.status_bits[ST_TRUNC] = 1'b1;
        end
        if (rem != 0)
            sum_l4(base + ihl, rem, dremain);
    endfunction

    function automatic void summarize_packet();
        int unsigned link_len;
        logic [15:0] et;
        sum_r    = '0;
        et       = '0;
        link_len = model_eth ? ETH_HDR_LEN : 0;
        if (model_eth)
        begin
            if (cap_count > ETH_HDR_LEN)
                et = hw(12);
        end
        else if (cap_count >= V4_MIN_LEN)
        begin
            if (hb(0) == IPV4_SNIFF)
                et = ETYPE_IPV4;
            else if (hb(0) >> 4 == IPV6_NIBBLE)
                et = ETYPE_IPV6;
        end
        sum_r.ethertype = et;
        if (cap_count > link_len)
        begin
            if (et == ETYPE_IPV4)
                sum_v4(link_len, cap_count - link_len);
            else if (et == ETYPE_IPV6)
                sum_v6(link_len, cap_count - link_len);
        end
    endfunction

    function automatic void take_byte(logic [7:0] d, logic l);
        if (cap_count < SNAP_LENGTH)
        begin
            if (cap_count < HDR_KEEP)
                hdr_buf[cap_count] = d;
            cap_count++;
        end
        if (l)
        begin
            summarize_packet();
            summary_q.push_back(sum_r);
            cap_count = 0;
            foreach (hdr_buf[i])
                hdr_buf[i] = '0;
        end
    endfunction

    // ---------------- packet builders ----------------
    function automatic void put16(int unsigned v);
        pkt.push_back(v[15:8]);
        pkt.push_back(v[7:0]);
    endfunction

    function automatic void put_rand(int n);
        repeat (n)
            pkt.push_back($urandom_range(0, 255));
    endfunction

    function automatic void add_eth(int unsigned et);
        put_rand(12);
        put16(et);
    endfunction

    function automatic void add_v4(int unsigned vi, int unsigned tot, int unsigned proto);
        pkt.push_back(vi[7:0]);
        put_rand(1);
        put16(tot);
        put_rand(4);
        put_rand(1);
        pkt.push_back(proto[7:0]);
        put_rand(10);
        put_rand((vi & 4'hF) * 4 > 20 ? (vi & 4'hF) * 4 - 20 : 0);
    endfunction

    function automatic void add_v6(int unsigned plen, int unsigned nh);
        pkt.push_back(8'h60 | $urandom_range(0, 15));
        put_rand(3);
        put16(plen);
        pkt.push_back(nh[7:0]);
        put_rand(33);
    endfunction

    // opt holds raw option bytes; off is the data offset in 32-bit words
    function automatic void add_tcp(int unsigned off, logic [7:0] opt[$]);
        int room;
        put16($urandom_range(0, 65535));
        put16($urandom_range(0, 65535));
        put_rand(8);
        pkt.push_back({off[3:0], 4'($urandom_range(0, 15))});
        put_rand(7);
        room = int'(off) * 4 - 20;
        foreach (opt[i])
            if (i < room)
                pkt.push_back(opt[i]);
        for (int i = opt.size(); i < room; i++)
            pkt.push_back(OPT_NOP);
    endfunction

    function automatic void add_udp(int unsigned ulen);
        put16($urandom_range(0, 65535));
        put16($urandom_range(0, 65535));
        put16(ulen);
        put_rand(2);
    endfunction

    // emit the built bytes, keeping at most keep of them
    function automatic void send_packet(int keep);
        byte_word_t w;
        if (keep < 1)
            keep = 1;
        if (pkt.size() == 0)
            put_rand(1);
        while (pkt.size() > keep)
            void'(pkt.pop_back());
        foreach (pkt[i])
        begin
            w.d = pkt[i];
            w.l = (i == pkt.size() - 1);
            byte_fifo.push_back(w);
        end
        pkt.delete();
    endfunction

    function automatic void rand_options(ref logic [7:0] opt[$]);
        int n;
        int k;
        n = $urandom_range(0, 4);
        repeat (n)
        begin
            k = $urandom_range(0, 9);
            if (k < 4)
            begin
                opt.push_back(OPT_MSS);
                opt.push_back(OPT_MSS_LEN);
                opt.push_back($urandom_range(0, 255));
                opt.push_back($urandom_range(0, 255));
            end
            else if (k < 6)
                opt.push_back(OPT_NOP);
            else if (k == 6)
            begin
                opt.push_back(8'd3);
                opt.push_back(8'd3);
                opt.push_back($urandom_range(0, 14));
            end
            else if (k == 7)
            begin
                opt.push_back(OPT_MSS);
                opt.push_back($urandom_range(0, 12));
            end
            else
                opt.push_back($urandom_range(0, 255));
        end
    endfunction

    function automatic void rand_packet();
        logic [7:0] opt[$];
        bit          eth;
        int          l3;
        int          l4;
        int unsigned ihl;
        int unsigned off;
        int unsigned pay;
        int unsigned l4len;
        int unsigned proto;
        int          total;
        eth = ($urandom_range(0, 9) == 0) ? !model_eth : model_eth;
        l3  = $urandom_range(0, 9);
        l4  = $urandom_range(0, 9);
        pay = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
        proto = (l4 < 5) ? PROTO_TCP : (l4 < 9) ? PROTO_UDP : $urandom_range(0, 255);
        off = 5;
        if (proto == PROTO_TCP)
        begin
            rand_options(opt);
            off = (opt.size() + 23) / 4 + 5;
            if (off > 15)
                off = 15;
            if ($urandom_range(0, 9) == 0)
                off = $urandom_range(0, 15);
        end
        l4len = (proto == PROTO_TCP) ? off * 4 : 8;
        if (eth)
            add_eth(l3 < 5 ? ETYPE_IPV4 : l3 < 9 ? ETYPE_IPV6 : $urandom_range(0, 65535));
        if (l3 < 5 || (l3 == 9 && !eth))
        begin
            ihl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
            total = ihl * 4 + l4len + pay;
            if ($urandom_range(0, 7) == 0)
                total = $urandom_range(0, 65535);
            add_v4((l3 == 9) ? $urandom_range(0, 255) :
                   ($urandom_range(0, 15) == 0 ? 8'h60 : 8'h40) | ihl, total, proto);
        end
        else
        begin
            total = l4len + pay;
            if ($urandom_range(0, 7) == 0)
                total = $urandom_range(0, 65535);
            add_v6(total, proto);
        end
        if (proto == PROTO_TCP)
            add_tcp(off, opt);
        else
            add_udp(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : 8 + pay);
        put_rand(pay);
        send_packet(($urandom_range(0, 4) == 0) ? $urandom_range(1, pkt.size()) : pkt.size());
    endfunction

    // ---------------- directed packets (Ethernet framing unless noted) ----------------
    function automatic void directed_eth();
        logic [7:0] opt[$];
        put_rand(1);
        send_packet(1);
        add_eth(ETYPE_IPV4);
        send_packet(14);                          // Ethernet header only
        add_eth(ETYPE_IPV4);
        add_v4(8'h45, 40, PROTO_TCP);
        send_packet(15);
        add_eth($urandom_range(0, 65535));        // unknown type
        put_rand(40);
        send_packet(99);
        add_eth(ETYPE_IPV4);                      // version 6 on the IPv4 path
        add_v6(20, PROTO_TCP);
        add_tcp(5, opt);
        send_packet(99);
        add_eth(ETYPE_IPV4);                      // IHL below 20
        add_v4(8'h42, 30, PROTO_UDP);
        add_udp(8);
        put_rand(14);
        send_packet(99);
        add_eth(ETYPE_IPV4);                      // IHL over total length
        add_v4(8'h4F, 40, PROTO_TCP);
        send_packet(99);
        add_eth(ETYPE_IPV4);                      // zero remainder
        add_v4(8'h45, 20, PROTO_TCP);
        send_packet(99);
        add_eth(ETYPE_IPV4);                      // truncated TCP with real length
        add_v4(8'h45, 1400, PROTO_TCP);
        add_tcp(5, opt);
        put_rand(10);
        send_packet(99);
        add_eth(ETYPE_IPV4);                      // data offset under 20
        add_v4(8'h45, 60, PROTO_TCP);
        add_tcp(2, opt);
        put_rand(20);
        send_packet(99);
        add_eth(ETYPE_IPV4);                      // data offset beyond bytes
        add_v4(8'h45, 44, PROTO_TCP);
        add_tcp(5, opt);
        put_rand(4);
        pkt[14 + 20 + 12] = 8'hF0;
        send_packet(99);
        opt = '{OPT_NOP, OPT_MSS, OPT_MSS_LEN, 8'hFF, 8'hFF, OPT_MSS, 8'd0};
        add_eth(ETYPE_IPV6);                      // MSS then zero-length option
        add_v6(32, PROTO_TCP);
        add_tcp(8, opt);
        send_packet(99);
        opt = '{OPT_MSS, OPT_MSS_LEN, 8'h00, 8'h00, OPT_MSS, 8'd40};
        add_eth(ETYPE_IPV4);                      // option length past the room
        add_v4(8'h45, 52, PROTO_TCP);
        add_tcp(8, opt);
        send_packet(99);
        add_eth(ETYPE_IPV6);                      // UDP length under 8
        add_v6(8, PROTO_UDP);
        add_udp(3);
        send_packet(99);
        add_eth(ETYPE_IPV4);                      // UDP no content
        add_v4(8'h45, 28, PROTO_UDP);
        add_udp(8);
        send_packet(99);
        add_eth(ETYPE_IPV6);                      // TCP header cut short, extreme length
        add_v6(16'hFFFF, PROTO_TCP);
        add_tcp(5, opt);
        send_packet(60);
        add_eth(ETYPE_IPV4);                      // capture longer than the snap length
        add_v4(8'h45, 16'hFFFF, PROTO_UDP);
        add_udp(16'hFFFF);
        put_rand(SNAP_LENGTH + 200 - 42);
        send_packet(SNAP_LENGTH + 200);
    endfunction

    function automatic void directed_raw();
        logic [7:0] opt[$];
        add_v4(8'h45, 40, PROTO_TCP);
        send_packet(19);                          // too short to sniff
        add_v4(8'h45, 40, PROTO_TCP);
        add_tcp(5, opt);
        send_packet(99);
        add_v4(8'h46, 40, PROTO_TCP);             // not a sniffable first byte
        send_packet(99);
        add_v6(8, PROTO_UDP);
        add_udp(8);
        send_packet(99);
        add_v6(8, PROTO_UDP);
        send_packet(39);                          // IPv6 header cut short
    endfunction

    // ---------------- sequencing ----------------
    task automatic settle();
        wait (byte_fifo.size() == 0 && !in_valid && summary_q.size() == 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(bit eth, bit guess, int count, bit calm);
        settle();
        write_reg(CFG_LINK_IS_ETH, eth);
        write_reg(CFG_GUESS_EN, guess);
        repeat (2) @(posedge clk);
        quiet = calm;
        for (int i = 0; i < count; i++)
            rand_packet();
        if (!eth)
            directed_raw();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = 1'b0;
        model_eth   = 1'b1;
        model_guess = 1'b0;
        quiet       = 1'b0;
        errors      = 0;
        cap_count   = 0;
        foreach (hdr_buf[i])
            hdr_buf[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults: Ethernet framing, no guess
        directed_eth();
        run_phase(1'b0, 1'b1, 10, 1'b0);
        run_phase(1'b1, 1'b1, 14, 1'b0);
        run_phase(1'b0, 1'b0, 8, 1'b1);
        run_phase(1'b1, 1'b0, 12, 1'b0);
        run_phase(1'b0, 1'b1, 8, 1'b0);
        run_phase(1'b1, 1'b1, 10, 1'b1);
        settle();
        repeat (20) @(posedge clk);
        $display("Covered %0d packets in %0d bytes across both framings and guess settings,",
                 packets_done, bytes_done);
        $display("including truncation, option walk and snap-length edge packets.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // byte driver
    always @(posedge clk)
    begin
        byte_word_t w;
        if (rst_n && (!in_valid || in_ready))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (byte_fifo.size() > 0)
            begin
                w = byte_fifo.pop_front();
                in_valid  <= 1'b1;
                data_byte <= w.d;
                last_byte <= w.l;
                in_gap    <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
        end
    endtask

    // monitor, output stall and watchdog
    always @(posedge clk)
    begin
        result_t e;
        if (!rst_n)
        begin
            in_gap      <= 0;
            out_stall   <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                take_byte(data_byte, last_byte);
                bytes_done++;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LINK_IS_ETH)
                    model_eth = cfg_data;
                else if (cfg_index == CFG_GUESS_EN)
                    model_guess = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                packets_done++;
                if (summary_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: summary word with none expected", $time);
                end
                else
                begin
                    e = summary_q.pop_front();
                    check_field("ethertype", e.ethertype, ethertype);
                    check_field("l3_kind", e.l3_kind, l3_kind);
                    check_field("ip_length", e.ip_length, ip_length);
                    check_field("ip_proto", e.ip_proto, ip_proto);
                    check_field("hop_limit", e.hop_limit, hop_limit);
                    check_field("l4_kind", e.l4_kind, l4_kind);
                    check_field("src_port", e.src_port, src_port);
                    check_field("dst_port", e.dst_port, dst_port);
                    check_field("tcp_flags", e.tcp_flags, tcp_flags);
                    check_field("tcp_mss", e.tcp_mss, tcp_mss);
                    check_field("content_length", e.content_length, content_length);
                    check_field("status_bits", e.status_bits, status_bits);
                end
            end
            // hold off the summary side at random
            if (out_stall > 0)
            begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall <= pick_gap();
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
